// ===== hdl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared codes, constants and the CRC-8 byte step for the serial frame
// receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // parser phases
    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_SYNC   = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_CHECK  = 3'd4;

    // result status codes
    localparam logic [2:0] ST_IGNORED   = 3'd0;
    localparam logic [2:0] ST_HEADER    = 3'd1;
    localparam logic [2:0] ST_PAYLOAD   = 3'd2;
    localparam logic [2:0] ST_GOOD      = 3'd3;
    localparam logic [2:0] ST_CRC_ERR   = 3'd4;
    localparam logic [2:0] ST_TOO_BIG   = 3'd5;
    localparam logic [2:0] ST_SYNC_LOST = 3'd6;

    // framing constants
    localparam logic [7:0] PREAMBLE_FIRST  = 8'h24;  // '$'
    localparam logic [7:0] PREAMBLE_SECOND = 8'h41;  // 'A'
    localparam logic [7:0] VARINT_DATA     = 8'h7F;
    localparam logic [7:0] VARINT_MORE     = 8'h80;
    localparam logic [7:0] BUFFER_SIZE     = 8'd128;
    localparam logic [4:0] SHIFT_LIMIT     = 5'd21;
    localparam logic [4:0] SHIFT_STEP      = 5'd7;
    localparam logic [4:0] SHIFT_MAX_USED  = 5'd16;
    localparam logic [7:0] CRC_POLY        = 8'hD5;

    // result item fields
    typedef struct packed {
        logic [7:0] frame_length;
        logic [6:0] byte_index;
        logic [7:0] payload_byte;
        logic [2:0] status;
    } t_result;

    // CRC-8 DVB-S2, MSB first, one byte per call
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== hdl/serial_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Byte-serial deframer: '$' 'A' preamble, varint length, payload and a
// closing CRC-8 DVB-S2 byte. One status result per received byte.
// ----------------------------------------------------------------------------
//  channel   | direction | request contents (lowest bit first)
//  s_axis    | in        | tdata[7:0] rx_byte
//  m_axis    | out       | tdata[2:0] status, [10:3] payload_byte,
//            |           |   [17:11] byte_index, [25:18] frame_length
//  cfg       | in        | wr_data[7:0] max_payload_len
//
//  One byte per cycle sustained while m_axis accepts; the parser update is one combinational step.
//  The path holds two registers: input register, then result register.
//  The input register takes a new request while a result waits downstream, if it is itself empty.
//  Synchronous active-low reset: hunting, CRC and counters cleared,
//  max_payload_len back to 128. Stalls only when both stages are full and m_axis is not ready.
// ----------------------------------------------------------------------------
module serial_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,    // [2:0] status, [10:3] payload_byte,
                                           // [17:11] byte_index, [25:18] frame_length
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data      // [7:0] max_payload_len
);

    import sfr_pkg::*;

    // configuration
    logic [7:0]  r_max;

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // parser state
    logic [2:0]  r_phase,  n_phase;
    logic [7:0]  r_crc,    n_crc;
    logic [15:0] r_len,    n_len;
    logic [4:0]  r_shift,  n_shift;
    logic [7:0]  r_cnt,    n_cnt;

    // result stage
    logic        r_out_valid;
    t_result     r_out,    n_out;

    logic        w_out_ready;
    logic        w_in_ready;
    logic        w_proc;
    logic [7:0]  w_limit;
    logic [7:0]  w_crc_step;
    logic [15:0] w_len_bits;
    logic [5:0]  w_shift_sum;
    logic [7:0]  w_cnt_inc;

    // handshake between stages
    assign w_out_ready     = !r_out_valid || i_m_axis_tready;
    assign w_in_ready      = !r_in_valid || w_out_ready;
    assign w_proc          = r_in_valid && w_out_ready;
    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out};

    // shared datapath pieces
    assign w_limit     = (r_max > BUFFER_SIZE) ? BUFFER_SIZE : r_max;
    assign w_crc_step  = crc8_step(r_crc, r_in_byte);
    assign w_len_bits  = (r_shift < SHIFT_MAX_USED)
                       ? ({9'd0, r_in_byte[6:0]} << r_shift[3:0]) : 16'd0;
    assign w_shift_sum = {1'b0, r_shift} + {1'b0, SHIFT_STEP};
    assign w_cnt_inc   = r_cnt + 8'd1;

    // parser step
    always_comb begin
        n_phase = r_phase;
        n_crc   = r_crc;
        n_len   = r_len;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_out   = '0;
        case (r_phase)
            PH_SYNC: begin
                if (r_in_byte == PREAMBLE_SECOND) begin
                    n_phase      = PH_LENGTH;
                    n_out.status = ST_HEADER;
                end else begin
                    n_phase      = PH_HUNT;
                    n_out.status = ST_SYNC_LOST;
                end
            end
            PH_LENGTH: begin
                n_crc        = w_crc_step;
                n_len        = r_len | w_len_bits;
                n_shift      = (w_shift_sum > {1'b0, SHIFT_LIMIT})
                             ? SHIFT_LIMIT : w_shift_sum[4:0];
                n_out.status = ST_HEADER;
                if (r_in_byte < VARINT_MORE) begin
                    if (n_len > {8'd0, w_limit}) begin
                        n_phase      = PH_HUNT;
                        n_crc        = '0;
                        n_len        = '0;
                        n_shift      = '0;
                        n_cnt        = '0;
                        n_out.status = ST_TOO_BIG;
                    end else begin
                        n_phase = (n_len != 16'd0) ? PH_DATA : PH_CHECK;
                    end
                end
            end
            PH_DATA: begin
                n_crc              = w_crc_step;
                n_cnt              = w_cnt_inc;
                n_out.status       = ST_PAYLOAD;
                n_out.payload_byte = r_in_byte;
                n_out.byte_index   = r_cnt[6:0];
                if ({8'd0, w_cnt_inc} >= r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (r_in_byte == r_crc) begin
                    n_out.status       = ST_GOOD;
                    n_out.frame_length = r_len[7:0];
                end else begin
                    n_out.status = ST_CRC_ERR;
                end
                n_phase = PH_HUNT;
                n_crc   = '0;
                n_len   = '0;
                n_shift = '0;
                n_cnt   = '0;
            end
            default: begin
                // hunting; stray codes behave the same
                n_phase = (r_in_byte == PREAMBLE_FIRST) ? PH_SYNC : PH_HUNT;
                n_crc   = '0;
                n_len   = '0;
                n_shift = '0;
                n_cnt   = '0;
                n_out.status = (r_in_byte == PREAMBLE_FIRST) ? ST_HEADER : ST_IGNORED;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= BUFFER_SIZE;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HUNT;
            r_crc       <= '0;
            r_len       <= '0;
            r_shift     <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            if (w_in_ready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (w_proc) begin
                r_phase <= n_phase;
                r_crc   <= n_crc;
                r_len   <= n_len;
                r_shift <= n_shift;
                r_cnt   <= n_cnt;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // byte waiting in the input stage is held while the result stage is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_ready) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input stage lost or changed a waiting byte");

    // payload count stays below the decoded length while taking payload
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> ({8'd0, r_cnt} < r_len))
        else $error("payload count reached length while still in data phase");

    // closing byte always returns the parser to hunting
    a_check_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_phase == PH_CHECK) |=> (r_phase == PH_HUNT && r_crc == 8'd0))
        else $error("parser did not restart after the CRC byte");

    // a good frame never reports more than the buffer size
    a_good_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_GOOD) |-> (r_out.frame_length <= BUFFER_SIZE))
        else $error("frame good with length above buffer size");
`endif

endmodule
